FILE: hdl/skt_pkg.sv
// ----------------------------------------------------------------------------
// skt_pkg: shared types and codes for the sorted key table
// beat structs, command and status codes, sequencer states
// ----------------------------------------------------------------------------
package skt_pkg;

  localparam int CAPACITY_DEF = 128;
  localparam int KEY_W        = 31;
  localparam int PAY_W        = 32;
  localparam int RIDX_W       = 7;
  localparam int RPT_W        = 8;   // reported width of counts and positions
  localparam int GRP_SIZE     = 8;   // first level of the read select tree

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_DUPLICATE = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_DELETED   = 3'd3;
  localparam logic [2:0] ST_NOTFOUND  = 3'd4;
  localparam logic [2:0] ST_EMPTY     = 3'd5;
  localparam logic [2:0] ST_READOK    = 3'd6;
  localparam logic [2:0] ST_BAD       = 3'd7;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [KEY_W-1:0]  key;
    logic [PAY_W-1:0]  payload;
    logic [RIDX_W-1:0] read_index;
  } req_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [RPT_W-1:0] entry_total;
    logic [RPT_W-1:0] position;
    logic [KEY_W-1:0] out_key;
    logic [PAY_W-1:0] out_payload;
  } rsp_t;

  // control from the sequencer to the cell row
  typedef struct packed {
    logic cmp_en;  // cells register their compare flags
    logic dec_en;  // row registers position, hit flag and read data
    logic ins;     // open a slot at the search position
    logic del;     // close the slot at the search position
  } row_ctl_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_DEC,
    S_EXEC
  } state_t;

endpackage

FILE: hdl/sorted_key_table_top.sv
// ----------------------------------------------------------------------------
// sorted_key_table_top: sorted key table on a row of shifting cells
// insert, delete and indexed read over up to CAPACITY unique keys
// ----------------------------------------------------------------------------
// usage
//   req channel (req_valid, req_stall, req): one command beat, accepted at a
//   rising edge with req_valid high and req_stall low
//   rsp channel (rsp_valid, rsp_stall, rsp): exactly one result beat per
//   command, in command order
// timing
//   a command passes compare, decode and apply steps over the cell row; the
//   result is registered at the end of the apply step, and a new command is
//   taken only once the sequencer is back in idle; all slots compare and shift
//   in parallel, so this does not depend on the fill level
// stall
//   a finished result sits in the output register; the next command is still
//   accepted and runs up to its apply step, where it waits until the pending
//   result beat is taken
// reset
//   rst clears the entry count, the sequencer and the output valid; the
//   slots themselves are not cleared, only slots below the count are read
// ----------------------------------------------------------------------------
module sorted_key_table_top #(
  parameter int CAPACITY = skt_pkg::CAPACITY_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  skt_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output skt_pkg::rsp_t rsp
);
  import skt_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int WID_W = (CNT_W > RIDX_W) ? CNT_W : RIDX_W;

  state_t   state, state_next;
  req_t     cur;             // command in flight
  logic [CNT_W-1:0] count, count_next;
  row_ctl_t ctl;

  logic [CNT_W-1:0] pos;
  logic             hit;
  logic [KEY_W-1:0] rd_key;
  logic [PAY_W-1:0] rd_payload;

  logic go;                  // output register free for a new result
  rsp_t res;

  // the cell row does the search and the shifting
  skt_row #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W)
  ) u_row (
    .clk         (clk),
    .ctl         (ctl),
    .count       (count),
    .new_key     (cur.key),
    .new_payload (cur.payload),
    .read_index  (cur.read_index),
    .pos         (pos),
    .hit         (hit),
    .rd_key      (rd_key),
    .rd_payload  (rd_payload)
  );

  assign go        = !rsp_valid || !rsp_stall;
  assign req_stall = (state != S_IDLE);

  // result and count update for the command in flight
  always_comb begin
    res         = '0;
    count_next  = count;
    res.status  = ST_BAD;
    unique case (cur.cmd)
      CMD_INSERT: begin
        if (cur.key != '0) begin
          res.position = RPT_W'(pos);
          if (count == CNT_W'(CAPACITY)) begin
            res.status = ST_FULL;
          end else if (hit) begin
            res.status = ST_DUPLICATE;
          end else begin
            res.status = ST_INSERTED;
            count_next = count + 1'b1;
          end
        end
      end
      CMD_DELETE: begin
        if (cur.key != '0) begin
          if (count == '0) begin
            res.status = ST_EMPTY;
          end else begin
            res.position = RPT_W'(pos);
            if (hit) begin
              res.status = ST_DELETED;
              count_next = count - 1'b1;
            end else begin
              res.status = ST_NOTFOUND;
            end
          end
        end
      end
      CMD_READ: begin
        res.position = RPT_W'(cur.read_index);
        if (WID_W'(cur.read_index) < WID_W'(count)) begin
          res.status      = ST_READOK;
          res.out_key     = rd_key;
          res.out_payload = rd_payload;
        end
      end
      default: begin
        res.status = ST_BAD;
      end
    endcase
    res.entry_total = RPT_W'(count_next);
  end

  // sequencer: next state and row control
  always_comb begin
    state_next = state;
    ctl        = '0;
    unique case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_CMP;
      end
      S_CMP: begin
        ctl.cmp_en = 1'b1;
        state_next = S_DEC;
      end
      S_DEC: begin
        ctl.dec_en = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        if (go) begin
          ctl.ins    = (res.status == ST_INSERTED);
          ctl.del    = (res.status == ST_DELETED);
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && req_valid) begin
      cur <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (state == S_EXEC && go) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // result payload, loaded only when the register is free
  always_ff @(posedge clk) begin
    if (state == S_EXEC && go) begin
      rsp <= res;
    end
  end

endmodule

FILE: hdl/skt_cell.sv
// ----------------------------------------------------------------------------
// skt_cell: one slot of the sorted row
// holds a key and payload, compares against the broadcast key, shifts with
// its neighbors on insert and delete
// ----------------------------------------------------------------------------
module skt_cell (
  input  logic                     clk,
  input  skt_pkg::row_ctl_t        ctl,
  input  logic                     valid,
  input  logic [skt_pkg::KEY_W-1:0] new_key,
  input  logic [skt_pkg::PAY_W-1:0] new_payload,
  input  logic                     prev_lt,
  input  logic [skt_pkg::KEY_W-1:0] prev_key,
  input  logic [skt_pkg::PAY_W-1:0] prev_payload,
  input  logic [skt_pkg::KEY_W-1:0] next_key,
  input  logic [skt_pkg::PAY_W-1:0] next_payload,
  output logic [skt_pkg::KEY_W-1:0] key,
  output logic [skt_pkg::PAY_W-1:0] payload,
  output logic                     lt,
  output logic                     eq
);
  import skt_pkg::*;

  always_ff @(posedge clk) begin
    if (ctl.cmp_en) begin
      lt <= valid && (key < new_key);
      eq <= valid && (key == new_key);
    end
    if (ctl.ins && !lt) begin
      // first slot not below the new key takes it, the rest move up
      if (prev_lt) begin
        key     <= new_key;
        payload <= new_payload;
      end else begin
        key     <= prev_key;
        payload <= prev_payload;
      end
    end else if (ctl.del && !lt) begin
      key     <= next_key;
      payload <= next_payload;
    end
  end

endmodule

FILE: hdl/skt_row.sv
// ----------------------------------------------------------------------------
// skt_row: the row of cells with its position encoder and read select tree
// ----------------------------------------------------------------------------
module skt_row #(
  parameter int CAPACITY = skt_pkg::CAPACITY_DEF,
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic                       clk,
  input  skt_pkg::row_ctl_t          ctl,
  input  logic [CNT_W-1:0]           count,
  input  logic [skt_pkg::KEY_W-1:0]  new_key,
  input  logic [skt_pkg::PAY_W-1:0]  new_payload,
  input  logic [skt_pkg::RIDX_W-1:0] read_index,
  output logic [CNT_W-1:0]           pos,
  output logic                       hit,
  output logic [skt_pkg::KEY_W-1:0]  rd_key,
  output logic [skt_pkg::PAY_W-1:0]  rd_payload
);
  import skt_pkg::*;

  localparam int RD_MAX = 1 << RIDX_W;
  localparam int RD_N   = (CAPACITY < RD_MAX) ? CAPACITY : RD_MAX;
  localparam int GRP_N  = (RD_N + GRP_SIZE - 1) / GRP_SIZE;
  localparam int SUB_W  = $clog2(GRP_SIZE);
  localparam int GSEL_W = RIDX_W - SUB_W;

  logic [KEY_W-1:0] keys [CAPACITY];
  logic [PAY_W-1:0] pays [CAPACITY];
  logic [CAPACITY-1:0] lt;
  logic [CAPACITY-1:0] eq;
  logic [CAPACITY:0]   bnd;

  logic [KEY_W-1:0] pad_key [GRP_N*GRP_SIZE];
  logic [PAY_W-1:0] pad_pay [GRP_N*GRP_SIZE];
  logic [KEY_W-1:0] grp_key [GRP_N];
  logic [PAY_W-1:0] grp_pay [GRP_N];
  logic [KEY_W-1:0] grp_key_next [GRP_N];
  logic [PAY_W-1:0] grp_pay_next [GRP_N];
  logic [KEY_W-1:0] rd_key_next;
  logic [PAY_W-1:0] rd_payload_next;

  logic [CNT_W-1:0] pos_enc;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic             c_prev_lt;
    logic [KEY_W-1:0] c_prev_key;
    logic [PAY_W-1:0] c_prev_pay;
    logic [KEY_W-1:0] c_next_key;
    logic [PAY_W-1:0] c_next_pay;

    if (i == 0) begin : g_head
      assign c_prev_lt  = 1'b1;
      assign c_prev_key = '0;
      assign c_prev_pay = '0;
    end else begin : g_mid
      assign c_prev_lt  = lt[i-1];
      assign c_prev_key = keys[i-1];
      assign c_prev_pay = pays[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign c_next_key = keys[i];
      assign c_next_pay = pays[i];
    end else begin : g_body
      assign c_next_key = keys[i+1];
      assign c_next_pay = pays[i+1];
    end

    skt_cell u_cell (
      .clk          (clk),
      .ctl          (ctl),
      .valid        (CNT_W'(i) < count),
      .new_key      (new_key),
      .new_payload  (new_payload),
      .prev_lt      (c_prev_lt),
      .prev_key     (c_prev_key),
      .prev_payload (c_prev_pay),
      .next_key     (c_next_key),
      .next_payload (c_next_pay),
      .key          (keys[i]),
      .payload      (pays[i]),
      .lt           (lt[i]),
      .eq           (eq[i])
    );

    if (i == 0) begin : g_b0
      assign bnd[i] = !lt[i];
    end else begin : g_bn
      assign bnd[i] = !lt[i] && lt[i-1];
    end
  end
  // every valid slot below the key: search ends past the last slot
  assign bnd[CAPACITY] = lt[CAPACITY-1];

  always_comb begin
    pos_enc = '0;
    for (int i = 0; i <= CAPACITY; i++) begin
      if (bnd[i]) pos_enc = pos_enc | CNT_W'(i);
    end
  end

  for (genvar j = 0; j < GRP_N * GRP_SIZE; j++) begin : g_pad
    if (j < RD_N) begin : g_live
      assign pad_key[j] = keys[j];
      assign pad_pay[j] = pays[j];
    end else begin : g_zero
      assign pad_key[j] = '0;
      assign pad_pay[j] = '0;
    end
  end

  // read tree, first level select
  always_comb begin
    for (int g = 0; g < GRP_N; g++) begin
      grp_key_next[g] = '0;
      grp_pay_next[g] = '0;
      for (int s = 0; s < GRP_SIZE; s++) begin
        if (read_index[SUB_W-1:0] == SUB_W'(s)) begin
          grp_key_next[g] = pad_key[g*GRP_SIZE+s];
          grp_pay_next[g] = pad_pay[g*GRP_SIZE+s];
        end
      end
    end
  end

  // read tree, second level select
  always_comb begin
    rd_key_next     = '0;
    rd_payload_next = '0;
    for (int g = 0; g < GRP_N; g++) begin
      if (read_index[RIDX_W-1:SUB_W] == GSEL_W'(g)) begin
        rd_key_next     = grp_key[g];
        rd_payload_next = grp_pay[g];
      end
    end
  end

  // first level registered while the cells compare
  always_ff @(posedge clk) begin
    if (ctl.cmp_en) begin
      for (int g = 0; g < GRP_N; g++) begin
        grp_key[g] <= grp_key_next[g];
        grp_pay[g] <= grp_pay_next[g];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.dec_en) begin
      pos        <= pos_enc;
      hit        <= |(bnd[CAPACITY-1:0] & eq);
      rd_key     <= rd_key_next;
      rd_payload <= rd_payload_next;
    end
  end

endmodule
